@@ src/sat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared constants, codes and types of the segment address translator.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int SEGMENTS_DEF   = 8;
	localparam int ADDR_WIDTH_DEF = 32;

	localparam int NUM_FIELDS = 6;
	localparam int PADDR_W    = 3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	localparam logic [2:0] FLD_REQ  = 3'd0;
	localparam logic [2:0] FLD_REAL = 3'd1;
	localparam logic [2:0] FLD_PHYS = 3'd2;
	localparam logic [2:0] FLD_LOAD = 3'd3;
	localparam logic [2:0] FLD_LEN  = 3'd4;
	localparam logic [2:0] FLD_FOFF = 3'd5;

	localparam logic [2:0] SPC_FILE = 3'd4;

	localparam logic REG_SEG_COUNT = 1'b0;

	typedef struct packed {
		logic       en;
		logic [2:0] field;
	} tbl_wr_t;

	// target space to table field
	function automatic logic [2:0] tgt_field(input logic [2:0] tgt);
		logic [2:0] f;
		f = (tgt == SPC_FILE) ? FLD_FOFF : tgt;
		return f;
	endfunction

endpackage

@@ src/sat_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_cmd_if / sat_rsp_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface sat_cmd_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [2:0]  entry_index;
	logic [2:0]  field_select;
	logic [31:0] write_value;
	logic [31:0] address;
	logic [1:0]  source_space;
	logic [2:0]  target_space;

	modport source (
		output valid, command, entry_index, field_select, write_value,
		       address, source_space, target_space,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, field_select, write_value,
		       address, source_space, target_space,
		output ready
	);
endinterface

interface sat_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] translated;
	logic        hit;

	modport source (output valid, translated, hit, input ready);
	modport sink (input valid, translated, hit, output ready);
endinterface

@@ src/segment_address_translator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_address_translator_unit
// Base/bound segment table with a sequential first-match translate scan.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (valid/ready): a write item stores one field of one entry; a
//   translate item maps an address from a source space to a target space.
//   rsp channel (valid/ready): one item per command: translated and hit.
//   A write, or a translate with an unknown target, returns 0 with hit clear.
//   APB port: segment_count at byte address 0, written while the block idles.
// Sequence:
//   A write item goes from acceptance through ST_DONE into the output register.
//   A translate scans one entry at a time, ST_READ then ST_CMP, through the single
//   table read port and the shared subtract/compare unit; a first hit passes ST_ADD
//   and ST_DONE into the output register, a miss only ST_DONE.
//   cmd.ready is high only while no item is in work; one item at a time.
// Reset: segment_count and all table entries read as zero after arst_n.
// Stall: the result sits in an output register; a new item is accepted while
//   it waits, and the scan holds its result until the register frees up.
// ----------------------------------------------------------------------------
module segment_address_translator_unit #(
	parameter int SEGMENTS   = sat_pkg::SEGMENTS_DEF,
	parameter int ADDR_WIDTH = sat_pkg::ADDR_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sat_cmd_if.sink                     cmd,
	sat_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sat_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import sat_pkg::*;

	localparam int AW = ADDR_WIDTH;
	localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CW = $clog2(SEGMENTS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	logic [3:0]      seg_count_q;
	logic [AW-1:0]   addr_q;
	logic [1:0]      src_q;
	logic [2:0]      tgt_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   lim_q;
	logic [AW-1:0]   delta_q;
	logic [AW-1:0]   tbase_q;
	logic [AW-1:0]   res_q;
	logic            hit_q;
	logic            out_vld_q;
	logic [31:0]     out_trans_q;
	logic            out_hit_q;

	logic            cmd_acc;
	logic            cfg_wr;
	logic            out_free;
	logic [CW-1:0]   lim_c;
	logic [AW-1:0]   delta_c;
	tbl_wr_t         tbl_wr;
	logic            rd_en;
	logic [NUM_FIELDS-1:0][AW-1:0] rd_data;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr[PADDR_W-1:2] == REG_SEG_COUNT);
	assign prdata = (paddr[PADDR_W-1:2] == REG_SEG_COUNT) ? {28'd0, seg_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= 4'd0;
		end else if (cfg_wr) begin
			seg_count_q <= pwdata[3:0];
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	assign lim_c = (7'(seg_count_q) > 7'(SEGMENTS)) ? CW'(SEGMENTS) : CW'(seg_count_q);

	assign tbl_wr.en    = cmd_acc && (cmd.command == CMD_WRITE) &&
	                      (7'(cmd.entry_index) < 7'(SEGMENTS)) &&
	                      (cmd.field_select <= FLD_FOFF);
	assign tbl_wr.field = cmd.field_select;
	assign rd_en        = (state_q == ST_READ) && (idx_q != lim_q);

	sat_table #(
		.SEGMENTS  (SEGMENTS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.wr_idx (IW'(cmd.entry_index)),
		.wr_data(AW'(cmd.write_value)),
		.rd_en  (rd_en),
		.rd_idx (idx_q[IW-1:0]),
		.rd_data(rd_data)
	);

	assign delta_c = addr_q - rd_data[{1'b0, src_q}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			lim_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						idx_q <= '0;
						lim_q <= lim_c;
						if (cmd.command == CMD_XLATE && cmd.target_space <= SPC_FILE)
							state_q <= ST_READ;
						else
							state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= (idx_q == lim_q) ? ST_DONE : ST_CMP;
				end
				ST_CMP: begin
					if (delta_c < rd_data[FLD_LEN]) begin
						state_q <= ST_ADD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_ADD: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			addr_q <= AW'(cmd.address);
			src_q  <= cmd.source_space;
			tgt_q  <= cmd.target_space;
			res_q  <= '0;
			hit_q  <= 1'b0;
		end
		if (state_q == ST_CMP) begin
			delta_q <= delta_c;
			tbase_q <= rd_data[tgt_field(tgt_q)];
		end
		if (state_q == ST_ADD) begin
			res_q <= delta_q + tbase_q;
			hit_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_trans_q <= 32'(res_q);
			out_hit_q   <= hit_q;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.translated = out_trans_q;
	assign rsp.hit        = out_hit_q;

endmodule

@@ src/sat_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_table
// Segment table: one memory per field, one write port, registered read of a
// whole row. Row valid bits make never-written rows read as zero.
// ----------------------------------------------------------------------------
module sat_table #(
	parameter int SEGMENTS   = 8,
	parameter int ADDR_WIDTH = 32,
	localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  sat_pkg::tbl_wr_t                              wr,
	input  logic [IW-1:0]                                 wr_idx,
	input  logic [ADDR_WIDTH-1:0]                         wr_data,
	input  logic                                          rd_en,
	input  logic [IW-1:0]                                 rd_idx,
	output logic [sat_pkg::NUM_FIELDS-1:0][ADDR_WIDTH-1:0] rd_data
);
	import sat_pkg::*;

	logic [SEGMENTS-1:0] row_valid_q;
	logic                rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr.en)
				row_valid_q[wr_idx] <= 1'b1;
			if (rd_en)
				rd_valid_q <= row_valid_q[rd_idx];
		end
	end

	for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_fld
		logic [ADDR_WIDTH-1:0] mem [SEGMENTS];
		logic [ADDR_WIDTH-1:0] rd_q;

		// first write to a row zeroes the other fields
		always_ff @(posedge clk) begin
			if (wr.en && (wr.field == 3'(f) || !row_valid_q[wr_idx]))
				mem[wr_idx] <= (wr.field == 3'(f)) ? wr_data : '0;
			if (rd_en)
				rd_q <= mem[rd_idx];
		end

		assign rd_data[f] = rd_valid_q ? rd_q : '0;
	end

endmodule

@@ src/sat_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_chk
// Port-level checks of the segment address translator, bound to the top.
// ----------------------------------------------------------------------------
module sat_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        cmd_command,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_translated,
	input logic        rsp_hit
);
	import sat_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("cmd ready right after an accepted item");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_translated) && $stable(rsp_hit)))
		else $error("stalled result changed or dropped");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_hit) |-> (rsp_translated == 32'd0))
		else $error("miss with nonzero address");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && cmd_command == CMD_WRITE) |=> ##1 rsp_valid)
		else $error("no result pending after a write item");

endmodule

bind segment_address_translator_unit sat_chk u_sat_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_command   (cmd.command),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_translated(rsp.translated),
	.rsp_hit       (rsp.hit)
);
